>>> sv/alts_pkg.sv
// Shared types and constants for the arc-length to segment parameter lookup.
`timescale 1ns / 1ps
`default_nettype none

package alts_pkg;

   // field widths
   localparam int LEN_W     = 31;   // unsigned Q15.16 cumulative length
   localparam int POS_W     = 32;   // signed Q15.16 query position
   localparam int IDX_W     = 10;   // entry index on write words
   localparam int SEG_W     = 10;   // segment index
   localparam int PARAM_W   = 17;   // Q1.16 segment parameter, 65536 = 1.0
   localparam int SPS_W     = 10;   // samples per segment register
   localparam int ENT_W     = 11;   // table entries register
   localparam int FRAC_BITS = 16;

   // shared divider geometry
   localparam int DIV_W = 17;       // dividend bits / quotient bits
   localparam int REM_W = 32;       // remainder and divisor
   localparam int CNT_W = 5;        // step counter

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_SPS     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES = 1'b1;

   // item kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [IDX_W-1:0]        entry_index;
      logic [LEN_W-1:0]        entry_length;
      logic signed [POS_W-1:0] query_position;
   } req_word_type;

   typedef struct packed {
      logic [SEG_W-1:0]   segment_index;
      logic [PARAM_W-1:0] segment_param;
      logic               out_of_range;
      logic               zero_gap;
   } rsp_word_type;

   // divider request from the sequencer
   typedef struct packed {
      logic             start;
      logic [REM_W-1:0] rem_init;
      logic [DIV_W-1:0] num;
      logic [CNT_W-1:0] steps;
      logic [REM_W-1:0] divisor;
   } div_cmd_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
      logic [REM_W-1:0] rem;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> sv/alts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module alts_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/alts_div.sv
// Shared restoring divider: one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module alts_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire alts_pkg::div_cmd_type div_cmd,
   output alts_pkg::div_rsp_type      div_rsp
);
   import alts_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] quo_ff, quo_in;

   logic [REM_W:0]   shifted;
   logic [REM_W:0]   trial;
   logic             fits;

   // one shift-subtract step; remainder stays below the divisor
   assign shifted = {rem_ff, num_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (div_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = div_cmd.steps;
         rem_in  = div_cmd.rem_init;
         dvs_in  = div_cmd.divisor;
         num_in  = div_cmd.num;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

>>> sv/arc_length_to_segment_param_top.sv
// Top level: arc-length table store and query sequencer around a shared divider.
// A write word does not leave the idle state, so the block stays ready for the next word.
// Queries are handled one at a time; an empty gap skips the fraction divide.
// Query time is set by the bit-serial shared divider and one RAM read per search probe.
// Synchronous reset clears the sequencer and the result valid flag and sets the registers
// (samples 1, entries 2); table contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module arc_length_to_segment_param_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire alts_pkg::req_word_type             req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output alts_pkg::rsp_word_type                  rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [alts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [alts_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import alts_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [17:0] DEPTH_W = 18'(TABLE_DEPTH);

   // sequencer states
   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_TOT_RD    = 5'd1;
   localparam logic [4:0] S_TOT_WAIT  = 5'd2;
   localparam logic [4:0] S_WRAP_HI   = 5'd3;
   localparam logic [4:0] S_WRAP_LO   = 5'd4;
   localparam logic [4:0] S_CHECK     = 5'd5;
   localparam logic [4:0] S_PROBE     = 5'd6;
   localparam logic [4:0] S_PROBE_CMP = 5'd7;
   localparam logic [4:0] S_LO_RD     = 5'd8;
   localparam logic [4:0] S_HI_RD     = 5'd9;
   localparam logic [4:0] S_HI_WAIT   = 5'd10;
   localparam logic [4:0] S_GAP       = 5'd11;
   localparam logic [4:0] S_CLAMP     = 5'd12;
   localparam logic [4:0] S_FRAC_GO   = 5'd13;
   localparam logic [4:0] S_FRAC_WAIT = 5'd14;
   localparam logic [4:0] S_SEG_GO    = 5'd15;
   localparam logic [4:0] S_SEG_WAIT  = 5'd16;
   localparam logic [4:0] S_T_GO      = 5'd17;
   localparam logic [4:0] S_T_WAIT    = 5'd18;
   localparam logic [4:0] S_OUT       = 5'd19;

   logic [4:0]            state_ff, state_in;
   logic [SPS_W-1:0]      sps_ff, sps_in;
   logic [ENT_W-1:0]      ent_ff, ent_in;
   logic signed [32:0]    s_ff, s_in;
   logic [LEN_W-1:0]      total_ff, total_in;
   logic [AW-1:0]         last_ff, last_in;
   logic [AW-1:0]         i_ff, i_in;
   logic [AW:0]           step_ff, step_in;
   logic [LEN_W-1:0]      lo_ff, lo_in;
   logic [LEN_W-1:0]      hi_ff, hi_in;
   logic signed [31:0]    gap_ff, gap_in;
   logic signed [32:0]    diff_ff, diff_in;
   logic                  zgap_ff, zgap_in;
   logic                  oor_ff, oor_in;
   logic [PARAM_W-1:0]    frac_ff, frac_in;
   logic [SEG_W-1:0]      seg_ff, seg_in;
   logic [SPS_W-1:0]      segrem_ff, segrem_in;
   logic [PARAM_W-1:0]    tval_ff, tval_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_ff, rsp_in;

   logic                  req_take;
   logic                  ram_we;
   logic [AW-1:0]         ram_wr_addr;
   logic [AW-1:0]         ram_rd_addr;
   logic [LEN_W-1:0]      ram_rd_data;
   logic [17:0]           ent_clamp;
   logic [SPS_W-1:0]      sps_eff;
   logic signed [32:0]    tot_s;
   logic signed [32:0]    rd_s;
   logic [AW:0]           cand;
   logic [26:0]           tnum;
   div_cmd_type           div_cmd;
   div_rsp_type           div_rsp;

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // table writes go straight into the RAM; out-of-range indexes are dropped
   assign ram_we      = req_take && (req_data.op == OP_WRITE)
                        && ({8'd0, req_data.entry_index} < DEPTH_W);
   assign ram_wr_addr = AW'(req_data.entry_index);

   alts_ram #(
      .WIDTH (LEN_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.entry_length),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   alts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   // entries in use clamped to [2, depth]; samples of zero act as one
   always_comb begin
      if (ent_ff < ENT_W'(2)) begin
         ent_clamp = 18'd2;
      end else if ({7'd0, ent_ff} > DEPTH_W) begin
         ent_clamp = DEPTH_W;
      end else begin
         ent_clamp = {7'd0, ent_ff};
      end
   end
   assign sps_eff = (sps_ff == '0) ? SPS_W'(1) : sps_ff;

   assign tot_s = $signed({2'b00, total_ff});
   assign rd_s  = $signed({2'b00, ram_rd_data});
   assign cand  = {1'b0, i_ff} + step_ff;
   assign tnum  = {1'b0, segrem_ff, 16'd0} + 27'(frac_ff);

   // RAM read address per state
   always_comb begin
      case (state_ff)
         S_TOT_RD: ram_rd_addr = last_ff;
         S_LO_RD:  ram_rd_addr = i_ff;
         S_HI_RD:  ram_rd_addr = i_ff + AW'(1);
         default:  ram_rd_addr = cand[AW-1:0];
      endcase
   end

   // configuration writes
   always_comb begin
      sps_in = sps_ff;
      ent_in = ent_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPS:     sps_in = csr_wdata[SPS_W-1:0];
            CSR_ENTRIES: ent_in = csr_wdata[ENT_W-1:0];
            default:     ;
         endcase
      end
   end

   // query sequencer
   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      i_in         = i_ff;
      step_in      = step_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      gap_in       = gap_ff;
      diff_in      = diff_ff;
      zgap_in      = zgap_ff;
      oor_in       = oor_ff;
      frac_in      = frac_ff;
      seg_in       = seg_ff;
      segrem_in    = segrem_ff;
      tval_in      = tval_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take && (req_data.op == OP_QUERY)) begin
               s_in     = {req_data.query_position[POS_W-1], req_data.query_position};
               last_in  = AW'(ent_clamp - 18'd1);
               state_in = S_TOT_RD;
            end
         end
         S_TOT_RD: state_in = S_TOT_WAIT;
         S_TOT_WAIT: begin
            total_in = ram_rd_data;
            state_in = S_WRAP_HI;
         end
         // wrap once into the loop
         S_WRAP_HI: begin
            if (s_ff >= tot_s) begin
               s_in = s_ff - tot_s;
            end
            state_in = S_WRAP_LO;
         end
         S_WRAP_LO: begin
            if (s_ff < 0) begin
               s_in = s_ff + tot_s;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            oor_in   = (s_ff < 0) || (s_ff >= tot_s);
            i_in     = '0;
            step_in  = {1'b1, {AW{1'b0}}};
            state_in = S_PROBE;
         end
         // binary search: probe only candidates inside the gaps
         S_PROBE: begin
            if (cand < {1'b0, last_ff}) begin
               state_in = S_PROBE_CMP;
            end else begin
               step_in = step_ff >> 1;
               if (step_ff[0]) begin
                  state_in = S_LO_RD;
               end
            end
         end
         S_PROBE_CMP: begin
            if (rd_s <= s_ff) begin
               i_in = cand[AW-1:0];
            end
            step_in  = step_ff >> 1;
            state_in = step_ff[0] ? S_LO_RD : S_PROBE;
         end
         S_LO_RD: state_in = S_HI_RD;
         S_HI_RD: begin
            lo_in    = ram_rd_data;
            state_in = S_HI_WAIT;
         end
         S_HI_WAIT: begin
            hi_in    = ram_rd_data;
            state_in = S_GAP;
         end
         S_GAP: begin
            gap_in   = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
            zgap_in  = (hi_ff <= lo_ff);
            diff_in  = s_ff - $signed({2'b00, lo_ff});
            state_in = S_CLAMP;
         end
         // clamp the offset into the gap
         S_CLAMP: begin
            if (diff_ff < 0) begin
               diff_in = '0;
            end else if (diff_ff > 33'(gap_ff)) begin
               diff_in = 33'(gap_ff);
            end
            if (zgap_ff) begin
               frac_in  = '0;
               state_in = S_SEG_GO;
            end else begin
               state_in = S_FRAC_GO;
            end
         end
         // fraction = (diff << 16) / gap, diff <= gap
         S_FRAC_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = REM_W'(diff_ff[31:1]);
            div_cmd.num      = {diff_ff[0], {FRAC_BITS{1'b0}}};
            div_cmd.steps    = CNT_W'(DIV_W);
            div_cmd.divisor  = REM_W'(gap_ff);
            state_in         = S_FRAC_WAIT;
         end
         S_FRAC_WAIT: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quo;
               state_in = S_SEG_GO;
            end
         end
         // gap index / samples per segment
         S_SEG_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = '0;
            div_cmd.num      = DIV_W'({i_ff, {(DIV_W-AW){1'b0}}});
            div_cmd.steps    = CNT_W'(AW);
            div_cmd.divisor  = REM_W'(sps_eff);
            state_in         = S_SEG_WAIT;
         end
         S_SEG_WAIT: begin
            if (div_rsp.done) begin
               seg_in    = div_rsp.quo[SEG_W-1:0];
               segrem_in = div_rsp.rem[SPS_W-1:0];
               state_in  = S_T_GO;
            end
         end
         // t = (rem * 65536 + fraction) / samples per segment
         S_T_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = REM_W'(tnum[26:17]);
            div_cmd.num      = tnum[16:0];
            div_cmd.steps    = CNT_W'(DIV_W);
            div_cmd.divisor  = REM_W'(sps_eff);
            state_in         = S_T_WAIT;
         end
         S_T_WAIT: begin
            if (div_rsp.done) begin
               tval_in  = div_rsp.quo;
               state_in = S_OUT;
            end
         end
         // hand the word to the result register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.segment_index = seg_ff;
               rsp_in.segment_param = tval_ff;
               rsp_in.out_of_range  = oor_ff;
               rsp_in.zero_gap      = zgap_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sps_ff       <= SPS_W'(1);
         ent_ff       <= ENT_W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sps_ff       <= sps_in;
         ent_ff       <= ent_in;
      end
      s_ff      <= s_in;
      total_ff  <= total_in;
      last_ff   <= last_in;
      i_ff      <= i_in;
      step_ff   <= step_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      gap_ff    <= gap_in;
      diff_ff   <= diff_in;
      zgap_ff   <= zgap_in;
      oor_ff    <= oor_in;
      frac_ff   <= frac_in;
      seg_ff    <= seg_in;
      segrem_ff <= segrem_in;
      tval_ff   <= tval_in;
      rsp_ff    <= rsp_in;
   end

endmodule

`default_nettype wire

>>> sv/alts_chk.sv
// Port-level checker for the arc-length lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module alts_chk (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire alts_pkg::req_word_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire alts_pkg::rsp_word_type rsp_data
);
   import alts_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // t never exceeds 1.0
   a_param_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.segment_param <= 17'd65536)
      else $error("segment parameter above one");

   // a table write produces no result word
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == OP_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a table write");

   // a query keeps the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == OP_QUERY) |=> req_stall)
      else $error("new word taken straight after a query");

endmodule

bind arc_length_to_segment_param_top alts_chk u_alts_chk (.*);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the arc-length table lookup: random stalls, own predictor, word checks.
`timescale 1ns / 1ps

module testbench;
   import alts_pkg::*;

   localparam int TABLE_DEPTH   = 1024;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 100;    // quiet time after the last answer is back
   localparam int WORD_TARGET   = 1850;

   typedef struct {
      req_word_type word;
      bit           hold_for_drain;     // sender waits until every answer is back
   } pending_word_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // words waiting to be sent, and answers waiting to arrive
   pending_word_type word_backlog[$];
   rsp_word_type     segment_answers[$];

   // table and register copies as the block sees them at acceptance
   longint            arc_table [TABLE_DEPTH];
   logic [SPS_W-1:0]  sps_mirror = 1;
   logic [ENT_W-1:0]  ent_mirror = 2;

   // table as planned by the stimulus, used to aim query positions
   longint            plan_table [TABLE_DEPTH];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  words_planned = 0;
   int  fail_count    = 0;
   int  cycle_count   = 0;
   bit  word_taken    = 1'b0;

   arc_length_to_segment_param_top #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // wrap, search, interpolate: expected answer for one query position
   function automatic rsp_word_type lookup_segment(input logic signed [POS_W-1:0] pos);
      int           n_ent, n_gaps, probe, gap_idx, sps;
      longint       s, total, lo, hi, span, diff, frac, tval;
      rsp_word_type ans;
      n_ent = (ent_mirror < 2) ? 2 : ((ent_mirror > TABLE_DEPTH) ? TABLE_DEPTH : ent_mirror);
      sps   = (sps_mirror == 0) ? 1 : sps_mirror;
      s     = pos;
      total = arc_table[n_ent-1];
      if (s >= total) s = s - total;
      if (s < 0) s = s + total;
      ans.out_of_range = (s < 0) || (s >= total);
      // last entry not above s among the first n_ent - 1
      n_gaps = n_ent - 1;
      probe  = 1;
      while (probe < n_gaps) probe = probe << 1;
      gap_idx = 0;
      while (probe != 0) begin
         if (gap_idx + probe < n_gaps && arc_table[gap_idx + probe] <= s) gap_idx += probe;
         probe = probe >> 1;
      end
      lo   = arc_table[gap_idx];
      hi   = arc_table[gap_idx + 1];
      span = hi - lo;
      ans.zero_gap = (span <= 0);
      if (span <= 0) begin
         frac = 0;
      end else begin
         diff = s - lo;
         if (diff < 0) diff = 0;
         if (diff > span) diff = span;
         frac = (diff << FRAC_BITS) / span;
      end
      tval = ((gap_idx % sps) * 65536 + frac) / sps;
      ans.segment_index = SEG_W'(gap_idx / sps);
      ans.segment_param = tval[PARAM_W-1:0];
      return ans;
   endfunction

   task automatic queue_write(input int unsigned idx, input logic [LEN_W-1:0] len);
      pending_word_type p;
      p.word.op             = OP_WRITE;
      p.word.entry_index    = idx[IDX_W-1:0];
      p.word.entry_length   = len;
      p.word.query_position = $urandom;
      p.hold_for_drain      = 1'b0;
      word_backlog.insert(word_backlog.size(), p);
      plan_table[idx[IDX_W-1:0]] = len;
      words_planned++;
   endtask

   task automatic queue_query(input logic [POS_W-1:0] pos, input bit hold);
      pending_word_type p;
      p.word.op             = OP_QUERY;
      p.word.entry_index    = IDX_W'($urandom);
      p.word.entry_length   = LEN_W'($urandom);
      p.word.query_position = pos;
      p.hold_for_drain      = hold;
      word_backlog.insert(word_backlog.size(), p);
      words_planned++;
   endtask

   // query position aimed at the loop, its entries, its wrap bands or anywhere
   function automatic logic [POS_W-1:0] pick_position(input int n);
      longint total, anchor, v;
      total  = plan_table[n-1];
      anchor = plan_table[$urandom_range(n-1, 0)];
      case ($urandom_range(9))
         0, 1, 2: v = (total > 0) ? $urandom_range(total - 1, 0) : anchor;
         3:       v = anchor;
         4:       v = anchor + $urandom_range(2) - 1;
         5:       v = $urandom_range(total, 0) - total;
         6:       v = total + $urandom_range(total, 0);
         7:       v = $urandom_range(1) ? 2 * total + $urandom_range(255)
                                        : -total - 1 - $urandom_range(255);
         default: v = $urandom;
      endcase
      return v[POS_W-1:0];
   endfunction

   // fill entries 0..n-1: rising lengths with some flat gaps, or raw random
   task automatic load_table(input int n, input bit scrambled);
      longint acc, cap;
      int     k;
      cap = 64'h7FFF_FFFF / n;
      case ($urandom_range(2))
         0:       if (cap > 256) cap = 256;
         1:       if (cap > 524288) cap = 524288;
         default: ;
      endcase
      acc = ($urandom_range(3) == 0) ? $urandom_range(cap, 0) : 0;
      for (k = 0; k < n; k++) begin
         if (scrambled) begin
            queue_write(k, LEN_W'($urandom));
         end else begin
            queue_write(k, LEN_W'(acc));
            acc += ($urandom_range(7) == 0) ? 0 : $urandom_range(cap, 1);
         end
      end
   endtask

   // wait for every word to be taken and answered, then let the block go quiet
   task automatic settle();
      while (word_backlog.size() != 0 || req_valid || segment_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_SPS) sps_mirror = val[SPS_W-1:0];
      else ent_mirror = val;
   endtask

   // one setting: configure while idle, optionally reload, then queries with noise writes
   task automatic run_phase(input int s_pct, input int r_pct,
                            input logic [CSR_DATA_W-1:0] sps_val,
                            input logic [CSR_DATA_W-1:0] ent_val,
                            input int load_mode, input int count);
      int n, k;
      settle();
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_csr(CSR_SPS, sps_val);
      write_csr(CSR_ENTRIES, ent_val);
      n = (ent_val < 2) ? 2 : ((ent_val > TABLE_DEPTH) ? TABLE_DEPTH : ent_val);
      if (load_mode != 0) load_table(n, load_mode == 2);
      for (k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0)
            queue_write($urandom_range(TABLE_DEPTH - 1), LEN_W'($urandom));
         queue_query(pick_position(n), $urandom_range(49) == 0);
      end
   endtask

   // sender: next word at the falling edge once the current one is taken
   always @(negedge clock) begin : drive_words
      pending_word_type nxt;
      if (!reset && (!req_valid || word_taken)) begin
         word_taken = 1'b0;
         if (word_backlog.size() != 0
             && !(word_backlog[0].hold_for_drain && segment_answers.size() != 0)
             && $urandom_range(99) >= send_idle_pct) begin
            nxt = word_backlog.pop_front();
            req_valid <= 1'b1;
            req_data  <= nxt.word;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // both handshakes sampled at the rising edge: answers checked, then words predicted
   always @(posedge clock) begin : watch_ports
      rsp_word_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("arc_length_to_segment_param_top: mismatch");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (segment_answers.size() == 0) begin
               $error("result word with no query outstanding");
               fail_count++;
            end else begin
               want = segment_answers.pop_front();
               if (rsp_data.segment_index !== want.segment_index) begin
                  $error("segment_index: expected %0d, got %0d",
                         want.segment_index, rsp_data.segment_index);
                  fail_count++;
               end
               if (rsp_data.segment_param !== want.segment_param) begin
                  $error("segment_param: expected %0d, got %0d",
                         want.segment_param, rsp_data.segment_param);
                  fail_count++;
               end
               if (rsp_data.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d",
                         want.out_of_range, rsp_data.out_of_range);
                  fail_count++;
               end
               if (rsp_data.zero_gap !== want.zero_gap) begin
                  $error("zero_gap: expected %0d, got %0d",
                         want.zero_gap, rsp_data.zero_gap);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            word_taken = 1'b1;
            if (req_data.op == OP_WRITE)
               arc_table[req_data.entry_index] = req_data.entry_length;
            else
               segment_answers.insert(segment_answers.size(),
                                      lookup_segment(req_data.query_position));
         end
      end
   end

   initial begin : stimulus
      int sps_pick, ent_pick, n_pick;
      send_idle_pct = 18;
      recv_idle_pct = 88;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed, reset settings: loop of zero length, every query out of range
      queue_write(0, 0);
      queue_write(1, 0);
      queue_query(32'h0000_0000, 1'b0);
      queue_query(32'h0000_0005, 1'b0);
      queue_query(32'hFFFF_FFFF, 1'b0);
      // longest loop, wraps at both ends and extreme positions
      queue_write(1, 31'h7FFF_FFFF);
      queue_query(32'h0000_0000, 1'b0);
      queue_query(32'h7FFF_FFFE, 1'b0);
      queue_query(32'h7FFF_FFFF, 1'b0);
      queue_query(32'hFFFF_FFFF, 1'b0);
      queue_query(32'h8000_0000, 1'b0);
      queue_query(32'h4000_0000, 1'b0);
      // loop not starting at zero: clamp below the first entry, half fraction, overshoot
      queue_write(0, 31'h0001_0000);
      queue_write(1, 31'h0003_0000);
      queue_query(32'h0002_0000, 1'b1);
      queue_query(32'h0001_0000, 1'b0);
      queue_query(32'h0000_0000, 1'b0);
      queue_query(32'h0002_FFFF, 1'b0);
      queue_query(32'h0003_0000, 1'b0);
      queue_query(32'hFFFF_0000, 1'b0);
      queue_query(32'h0007_0000, 1'b0);
      queue_query(32'hFFFC_0000, 1'b0);

      // sender idles a little, receiver a lot
      run_phase(18, 88, 11'd0, 11'd0, 1, 40);
      run_phase(18, 88, 11'd4, 11'd17, 1, 80);
      run_phase(18, 88, 11'd3, 11'd1, 2, 30);
      // the other way round, full-depth table
      run_phase(88, 18, 11'd1, 11'd1024, 1, 80);
      run_phase(88, 18, 11'h7FF, 11'h7FF, 0, 60);
      // no idling: random settings until the word budget is spent
      while (words_planned < WORD_TARGET) begin
         sps_pick = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(16, 1);
         ent_pick = ($urandom_range(4) == 0) ? $urandom_range(2047) : $urandom_range(48, 2);
         n_pick   = (ent_pick < 2) ? 2 : ((ent_pick > TABLE_DEPTH) ? TABLE_DEPTH : ent_pick);
         run_phase(0, 0, CSR_DATA_W'(sps_pick), CSR_DATA_W'(ent_pick),
                   (n_pick > 64) ? 0 : (($urandom_range(3) == 0) ? 2 : 1), 50);
      end
      settle();

      if (fail_count == 0)
         $display("arc_length_to_segment_param_top: match");
      else
         $display("arc_length_to_segment_param_top: mismatch");
      $finish;
   end

endmodule

>>> files.f
sv/alts_pkg.sv
sv/alts_ram.sv
sv/alts_div.sv
sv/arc_length_to_segment_param_top.sv
sv/alts_chk.sv
bench/testbench.sv
